// ----- design/sfmt_pkg.sv -----
// Shared types and constants of the SFMT generator.
`default_nettype none
package sfmt_pkg;
  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_HIGH = 2'd3;

  localparam logic [31:0] SEED_MULT  = 32'd1812433253;
  localparam int unsigned SEED_SHIFT = 30;
  localparam int unsigned ROW_W      = 128;
endpackage
`default_nettype wire

// ----- design/sfmt_if.sv -----
// Valid/ready channel interfaces for commands and random words.
`default_nettype none
interface sfmt_in_if;
  logic               valid;
  logic               ready;
  sfmt_pkg::cmd_e     cmd;
  logic [31:0]        seed_value;
  modport source (output valid, cmd, seed_value, input ready);
  modport sink   (input valid, cmd, seed_value, output ready);
endinterface

interface sfmt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  modport source (output valid, random_word, input ready);
  modport sink   (input valid, random_word, output ready);
endinterface
`default_nettype wire

// ----- design/sfmt_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module sfmt_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 156
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule
`default_nettype wire

// ----- design/sfmt_random_generator_top.sv -----
// Top level of the SFMT generator with lung word.
// One command at a time. A seed runs in the seed state until the next command
// can be taken (one recurrence multiply per word) and gives no word. A draw
// passes the draw read and draw output states to the output register, waiting
// in the output state while the output is held, and the next command is taken
// once the word is loaded; every 4*BLOCKS draws, one draw first regenerates the
// store: a priming state for the reads, then a read and a write state of the
// block RAM per 128-bit block. Rows never written read as zero.
`default_nettype none
module sfmt_random_generator_top #(
  parameter int unsigned BLOCKS             = 156,
  parameter int unsigned PICK_OFFSET        = 122,
  parameter int unsigned WORD_LEFT_SHIFT    = 18,
  parameter int unsigned BYTE_LEFT_SHIFT    = 1,
  parameter int unsigned MASKED_RIGHT_SHIFT = 11,
  parameter int unsigned WORD_RIGHT_SHIFT   = 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sfmt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sfmt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  sfmt_in_if.sink                               in_i,
  sfmt_out_if.source                            out_o
);
  localparam int unsigned AW    = $clog2(BLOCKS);
  localparam int unsigned GEN   = 4 * BLOCKS;
  localparam int unsigned IW    = $clog2(GEN + 1);
  localparam int unsigned JW    = $clog2(GEN + 4);
  localparam int unsigned PICK0 = PICK_OFFSET % BLOCKS;
  localparam int unsigned RW    = sfmt_pkg::ROW_W;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SEED     = 7'b0000010,
    ST_RG_PRE   = 7'b0000100,
    ST_RG_RD    = 7'b0001000,
    ST_RG_WR    = 7'b0010000,
    ST_DRAW_RD  = 7'b0100000,
    ST_DRAW_OUT = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [63:0]     mask_lo_q, mask_hi_q, par_lo_q, par_hi_q;
  logic [IW-1:0]   idx_q;
  logic [JW-1:0]   j_q;
  logic [AW-1:0]   i_q, bidx_q;
  logic [RW-1:0]   row_q, lung_q, c_q;
  logic [BLOCKS-1:0] vld_q;
  logic            va_q, vb_q;
  logic            ov_q;
  logic [31:0]     word_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, raddr_a, raddr_b;
  logic [RW-1:0]   ram_wdata, rd_a, rd_b, rda_v, rdb_v;

  sfmt_ram #(.WIDTH(RW), .DEPTH(BLOCKS)) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rd_b)
  );

  assign rda_v = va_q ? rd_a : '0;
  assign rdb_v = vb_q ? rd_b : '0;

  // seed recurrence
  logic [31:0]   prev_w, mix_w, new_w;
  logic [RW-1:0] seed_row;
  logic [JW-2-1:0] seed_blk;
  assign prev_w   = row_q[RW-1 -: 32];
  assign mix_w    = prev_w ^ (prev_w >> sfmt_pkg::SEED_SHIFT);
  assign new_w    = (sfmt_pkg::SEED_MULT * mix_w) + 32'(j_q);
  assign seed_row = {new_w, row_q[RW-1:32]};
  assign seed_blk = j_q[JW-1:2];

  // parity fix
  logic [RW-1:0] par_all, lung_fix;
  logic [31:0]   pw [4];
  logic          odd;
  assign par_all = {par_hi_q, par_lo_q};
  assign odd     = ^(seed_row & par_all);
  always_comb begin
    lung_fix = seed_row;
    for (int k = 0; k < 4; k++) begin
      pw[k] = par_all[32*k +: 32];
    end
    if (!odd) begin
      priority if (pw[0] != '0) lung_fix[31:0]   = seed_row[31:0]   ^ (pw[0] & (~pw[0] + 32'd1));
      else if (pw[1] != '0)     lung_fix[63:32]  = seed_row[63:32]  ^ (pw[1] & (~pw[1] + 32'd1));
      else if (pw[2] != '0)     lung_fix[95:64]  = seed_row[95:64]  ^ (pw[2] & (~pw[2] + 32'd1));
      else if (pw[3] != '0)     lung_fix[127:96] = seed_row[127:96] ^ (pw[3] & (~pw[3] + 32'd1));
      else                      lung_fix = seed_row;
    end
  end

  // block recursion
  logic [RW-1:0] xsh, y;
  logic [31:0]   mk [4];
  logic [31:0]   dk [4];
  assign xsh = rda_v << (8 * BYTE_LEFT_SHIFT);
  always_comb begin
    mk[0] = mask_lo_q[31:0];
    mk[1] = mask_lo_q[63:32];
    mk[2] = mask_hi_q[31:0];
    mk[3] = mask_hi_q[63:32];
    dk[0] = lung_q[127:96];
    dk[1] = lung_q[95:64];
    dk[2] = lung_q[31:0];
    dk[3] = lung_q[63:32];
    for (int k = 0; k < 4; k++) begin
      y[32*k +: 32] = rda_v[32*k +: 32] ^ xsh[32*k +: 32]
                    ^ ((rdb_v[32*k +: 32] >> MASKED_RIGHT_SHIFT) & mk[k])
                    ^ (c_q[32*k +: 32] >> WORD_RIGHT_SHIFT)
                    ^ (c_q[32*k +: 32] << WORD_LEFT_SHIFT)
                    ^ dk[k];
    end
  end

  logic in_acc, out_load;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_DRAW_OUT) && (!ov_q || out_o.ready);

  always_comb begin
    raddr_a = i_q;
    if (state_q == ST_DRAW_RD || state_q == ST_DRAW_OUT) begin
      raddr_a = AW'(idx_q >> 2);
    end
    raddr_b   = (state_q == ST_RG_PRE) ? AW'(BLOCKS - 1) : bidx_q;
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = y;
    if (state_q == ST_SEED && j_q[1:0] == 2'd3 && 32'(seed_blk) < 32'(BLOCKS)) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(seed_blk);
      ram_wdata = seed_row;
    end else if (state_q == ST_RG_WR) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.cmd == sfmt_pkg::CMD_SEED) state_d = ST_SEED;
          else if (32'(idx_q) >= 32'(GEN))    state_d = ST_RG_PRE;
          else                                state_d = ST_DRAW_RD;
        end
      end
      ST_SEED: begin
        if (j_q[1:0] == 2'd3 && 32'(seed_blk) == 32'(BLOCKS)) state_d = ST_IDLE;
      end
      ST_RG_PRE:   state_d = ST_RG_RD;
      ST_RG_RD:    state_d = ST_RG_WR;
      ST_RG_WR:    state_d = (i_q == AW'(BLOCKS - 1)) ? ST_DRAW_RD : ST_RG_RD;
      ST_DRAW_RD:  state_d = ST_DRAW_OUT;
      ST_DRAW_OUT: if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mask_lo_q <= '0;
      mask_hi_q <= '0;
      par_lo_q  <= 64'd1;
      par_hi_q  <= '0;
      idx_q     <= '0;
      vld_q     <= '0;
      lung_q    <= '0;
      ov_q      <= 1'b0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      va_q    <= vld_q[raddr_a];
      vb_q    <= vld_q[raddr_b];
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sfmt_pkg::CFG_MASK_LOW:    mask_lo_q <= cfg_data_i;
          sfmt_pkg::CFG_MASK_HIGH:   mask_hi_q <= cfg_data_i;
          sfmt_pkg::CFG_PARITY_LOW:  par_lo_q  <= cfg_data_i;
          sfmt_pkg::CFG_PARITY_HIGH: par_hi_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (ram_we) vld_q[ram_waddr] <= 1'b1;
      if (state_q == ST_SEED && state_d == ST_IDLE) begin
        lung_q <= lung_fix;
        idx_q  <= IW'(GEN);
      end
      if (state_q == ST_RG_WR) begin
        lung_q <= lung_q ^ y;
        if (state_d == ST_DRAW_RD) idx_q <= '0;
      end
      if (out_load) begin
        ov_q  <= 1'b1;
        idx_q <= idx_q + 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q  <= {in_i.seed_value, 96'd0};
      j_q    <= JW'(1);
      i_q    <= '0;
      bidx_q <= AW'(PICK0);
    end
    if (state_q == ST_SEED) begin
      row_q <= seed_row;
      j_q   <= j_q + 1'b1;
    end
    if (state_q == ST_RG_RD && i_q == '0) c_q <= rdb_v;
    if (state_q == ST_RG_WR) begin
      c_q    <= y;
      i_q    <= i_q + 1'b1;
      bidx_q <= (bidx_q == AW'(BLOCKS - 1)) ? '0 : bidx_q + 1'b1;
    end
    if (out_load) word_q <= rda_v[32 * idx_q[1:0] +: 32];
  end

  assign out_o.valid       = ov_q;
  assign out_o.random_word = word_q;

`ifndef ASSERT_OFF
  a_regen_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RG_WR && i_q == AW'(BLOCKS - 1)) |=> (idx_q == '0))
    else $error("index not reset after regeneration");
  a_out_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == ST_DRAW_OUT))
    else $error("word produced outside a draw");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(idx_q) <= 32'(GEN))
    else $error("read index out of range");
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SEED || state_q == ST_RG_WR))
    else $error("store written outside seed or regeneration");
`endif
endmodule
`default_nettype wire

// ----- tb/tb_sfmt_random_generator_top.sv -----
// Self-checking testbench for the SFMT generator: seeds, draws and register settings.
module tb_sfmt_random_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBLK  = 156;
  localparam int unsigned PICK  = 122;
  localparam int unsigned WLS   = 18;
  localparam int unsigned BLS   = 1;
  localparam int unsigned MRS   = 11;
  localparam int unsigned WRS   = 1;
  localparam int unsigned NWORD = (NBLK + 1) * 4;
  localparam int unsigned GENW  = NBLK * 4;
  localparam int unsigned LUNGW = NBLK * 4;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 2 * NWORD;

  class sfmt_scoreboard;
    logic [31:0] words[NWORD];
    int unsigned rd_idx;
    logic [63:0] mask_lo, mask_hi, par_lo, par_hi;
    logic [31:0] pending_words[$];
    int unsigned errors;

    function new();
      foreach (words[i]) words[i] = '0;
      rd_idx = 0;
      mask_lo = '0;
      mask_hi = '0;
      par_lo = 64'd1;
      par_hi = '0;
      errors = 0;
    endfunction

    function logic [31:0] half(logic [63:0] lo, logic [63:0] hi, int unsigned k);
      logic [63:0] v;
      v = (k < 2) ? lo : hi;
      return (k & 1) ? v[63:32] : v[31:0];
    endfunction

    function void write_reg(logic [sfmt_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        sfmt_pkg::CFG_MASK_LOW: mask_lo = val;
        sfmt_pkg::CFG_MASK_HIGH: mask_hi = val;
        sfmt_pkg::CFG_PARITY_LOW: par_lo = val;
        default: par_hi = val;
      endcase
    endfunction

    function void recur(int unsigned ai, int unsigned bi, int unsigned ci);
      logic [127:0] t, sh;
      logic [31:0] nv[4];
      int unsigned lp[4];
      lp = '{3, 2, 0, 1};
      t = {words[ai*4+3], words[ai*4+2], words[ai*4+1], words[ai*4]};
      sh = t << (BLS * 8);
      for (int k = 0; k < 4; k++) begin
        nv[k] = words[ai*4+k] ^ sh[k*32 +: 32]
              ^ ((words[bi*4+k] >> MRS) & half(mask_lo, mask_hi, k))
              ^ (words[ci*4+k] >> WRS) ^ (words[ci*4+k] << WLS)
              ^ words[LUNGW + lp[k]];
      end
      for (int k = 0; k < 4; k++) words[ai*4+k] = nv[k];
    endfunction

    function void seed(logic [31:0] s);
      logic [31:0] p, acc, pw;
      words[0] = s;
      for (int unsigned i = 1; i < NWORD; i++) begin
        p = words[i-1];
        words[i] = sfmt_pkg::SEED_MULT * (p ^ (p >> sfmt_pkg::SEED_SHIFT)) + i;
      end
      rd_idx = GENW;
      acc = '0;
      for (int k = 0; k < 4; k++) acc ^= words[LUNGW+k] & half(par_lo, par_hi, k);
      if (!(^acc)) begin
        for (int k = 0; k < 4; k++) begin
          pw = half(par_lo, par_hi, k);
          if (pw != 0) begin
            words[LUNGW+k] ^= pw & (~pw + 32'd1);
            break;
          end
        end
      end
    endfunction

    function void note_command(sfmt_pkg::cmd_e c, logic [31:0] s);
      if (c == sfmt_pkg::CMD_SEED) begin
        seed(s);
        return;
      end
      if (rd_idx >= GENW) begin
        for (int unsigned i = 0; i < NBLK; i++) begin
          recur(i, (i + PICK) % NBLK, (i + NBLK - 1) % NBLK);
          for (int k = 0; k < 4; k++) words[LUNGW+k] ^= words[i*4+k];
        end
        rd_idx = 0;
      end
      pending_words.push_back(words[rd_idx]);
      rd_idx++;
    endfunction

    function void check_word(logic [31:0] w);
      logic [31:0] e;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %08h", w));
        return;
      end
      e = pending_words.pop_front();
      if (w !== e) report_mismatch($sformatf("random_word %08h, expected %08h", w, e));
    endfunction

    function void report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sfmt_pkg::CFG_IDX_W-1:0] cfg_idx_i = sfmt_pkg::CFG_MASK_LOW;
  logic [sfmt_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  sfmt_in_if in_ch();
  sfmt_out_if out_ch();

  sfmt_random_generator_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  sfmt_scoreboard sb = new();
  bit idle_enable = 1'b1;
  logic long_hold = 1'b0;
  int unsigned hold_off = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = sfmt_pkg::CMD_DRAW;
    in_ch.seed_value = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.random_word);
    if (in_ch.valid && in_ch.ready) sb.note_command(in_ch.cmd, in_ch.seed_value);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (!in_ch.valid && sb.pending_words.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sfmt_random_generator_top: mismatch");
      $finish;
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_enable && !out_ch.ready && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      hold_off <= $urandom_range(1, 8) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(sfmt_pkg::cmd_e c, logic [31:0] s);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.seed_value <= s;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [sfmt_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic random_cmds(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) send(sfmt_pkg::CMD_SEED, $urandom());
      else send(sfmt_pkg::CMD_DRAW, $urandom());
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // draws from the zero store before any seed
    for (int i = 0; i < 4; i++) send(sfmt_pkg::CMD_DRAW, 32'hffff_ffff);
    send(sfmt_pkg::CMD_SEED, 32'h0000_0000);
    for (int i = 0; i < 4; i++) send(sfmt_pkg::CMD_DRAW, 32'h0);
    send(sfmt_pkg::CMD_SEED, 32'hffff_ffff);
    send(sfmt_pkg::CMD_SEED, 32'h8000_0001);
    for (int i = 0; i < 6; i++) send(sfmt_pkg::CMD_DRAW, 32'h0);
    drain();

    // all-ones masks, zero parity words: parity fix does nothing
    write_reg(sfmt_pkg::CFG_MASK_LOW, '1);
    write_reg(sfmt_pkg::CFG_MASK_HIGH, '1);
    write_reg(sfmt_pkg::CFG_PARITY_LOW, '0);
    write_reg(sfmt_pkg::CFG_PARITY_HIGH, '0);
    send(sfmt_pkg::CMD_SEED, 32'd5489);
    for (int i = 0; i < 6; i++) send(sfmt_pkg::CMD_DRAW, 32'h0);
    drain();

    // parity word only in the top half
    write_reg(sfmt_pkg::CFG_PARITY_HIGH, 64'h8000_0000_0000_0000);
    send(sfmt_pkg::CMD_SEED, 32'd1234);
    send(sfmt_pkg::CMD_SEED, 32'd1235);
    send(sfmt_pkg::CMD_DRAW, 32'h0);
    drain();

    // long receiver stall while the sender keeps offering commands, mostly draws
    fork
      begin
        long_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        long_hold <= 1'b0;
      end
      random_cmds(40);
    join
    drain();

    write_reg(sfmt_pkg::CFG_MASK_LOW, rand64());
    write_reg(sfmt_pkg::CFG_MASK_HIGH, rand64());
    write_reg(sfmt_pkg::CFG_PARITY_LOW, rand64());
    write_reg(sfmt_pkg::CFG_PARITY_HIGH, rand64());
    random_cmds(700);
    drain();

    write_reg(sfmt_pkg::CFG_MASK_LOW, 64'hdfff_ffef_ddfe_cb7f);
    write_reg(sfmt_pkg::CFG_MASK_HIGH, 64'hbffa_ffff_bffa_ffff);
    write_reg(sfmt_pkg::CFG_PARITY_LOW, 64'h0000_0000_0000_0001);
    write_reg(sfmt_pkg::CFG_PARITY_HIGH, 64'h13c9_e684_0000_0000);
    random_cmds(400);
    drain();

    idle_enable = 1'b0;
    random_cmds(380);
    drain();

    if (sb.errors == 0 && sb.pending_words.size() == 0)
      $display("sfmt_random_generator_top: match");
    else
      $display("sfmt_random_generator_top: mismatch");
    $finish;
  end
endmodule

// ----- files.f -----
design/sfmt_pkg.sv
design/sfmt_if.sv
design/sfmt_ram.sv
design/sfmt_random_generator_top.sv
tb/tb_sfmt_random_generator_top.sv
